// ----- src/rv64ae_pkg.sv -----
package rv64ae_pkg;

    localparam int XLEN     = 64;
    localparam int REG_BITS = 5;
    localparam int NUM_REGS = 32;
    localparam int SH_BITS  = 6;

    localparam logic [6:0] OPC_ALU   = 7'h33;
    localparam logic [6:0] OPC_FENCE = 7'h0F;
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SLT     = 3'd2;
    localparam logic [2:0] F3_SLTU    = 3'd3;
    localparam logic [2:0] F3_XOR     = 3'd4;
    localparam logic [2:0] F3_SRL_SRA = 3'd5;
    localparam logic [2:0] F3_OR      = 3'd6;
    localparam logic [2:0] F3_AND     = 3'd7;

    localparam logic [2:0] ST_WRITTEN  = 3'd0;
    localparam logic [2:0] ST_ADVANCED = 3'd1;
    localparam logic [2:0] ST_HALT     = 3'd2;
    localparam logic [2:0] ST_LOADED   = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic [REG_BITS-1:0] REG_ZERO = '0;
    localparam logic [XLEN-1:0]     PC_STEP  = 64'd4;

    // Request class, settled in the front end.
    typedef enum logic [1:0] {
        K_LOAD,     // direct register load
        K_ALU,      // ALU op with a real destination
        K_ADV,      // advance pc only (fence, x0 dest, bad funct7)
        K_HALT      // unimplemented opcode
    } t_kind;

    typedef enum logic [3:0] {
        A_ADD, A_SUB, A_SLL, A_SLT, A_SLTU,
        A_XOR, A_SRL, A_SRA, A_OR, A_AND
    } t_alu;

    typedef struct packed {
        t_kind               kind;
        t_alu                alu;
        logic [REG_BITS-1:0] rd;
        logic [REG_BITS-1:0] rs1;
        logic [REG_BITS-1:0] rs2;
        logic [XLEN-1:0]     value;
    } t_op;

endpackage

// ----- src/rv64ae_ram.sv -----
module rv64ae_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rv64ae_front.sv -----
module rv64ae_front (
    input  logic               i_item_kind,
    input  logic [31:0]        i_instruction_word,
    input  logic [4:0]         i_load_index,
    input  logic [63:0]        i_load_value,
    output rv64ae_pkg::t_op    o_op
);
    import rv64ae_pkg::*;

    logic [6:0]          opc;
    logic [6:0]          f7;
    logic [2:0]          f3;
    logic [REG_BITS-1:0] rd;
    logic                alu_ok;
    t_alu                alu;

    assign opc = i_instruction_word[6:0];
    assign rd  = i_instruction_word[11:7];
    assign f3  = i_instruction_word[14:12];
    assign f7  = i_instruction_word[31:25];

    always_comb begin
        alu    = A_ADD;
        alu_ok = 1'b0;
        if (f7 == F7_BASE) begin
            alu_ok = 1'b1;
            case (f3)
                F3_ADD_SUB: alu = A_ADD;
                F3_SLL:     alu = A_SLL;
                F3_SLT:     alu = A_SLT;
                F3_SLTU:    alu = A_SLTU;
                F3_XOR:     alu = A_XOR;
                F3_SRL_SRA: alu = A_SRL;
                F3_OR:      alu = A_OR;
                default:    alu = A_AND;
            endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD_SUB) begin
            alu_ok = 1'b1;
            alu    = A_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SRL_SRA) begin
            alu_ok = 1'b1;
            alu    = A_SRA;
        end
    end

    always_comb begin
        o_op       = '0;
        o_op.alu   = alu;
        o_op.rs1   = i_instruction_word[19:15];
        o_op.rs2   = i_instruction_word[24:20];
        o_op.value = '0;
        if (i_item_kind) begin
            o_op.kind  = K_LOAD;
            o_op.rd    = i_load_index;
            o_op.value = i_load_value;
        end else if (opc == OPC_ALU) begin
            o_op.rd   = rd;
            o_op.kind = (alu_ok && rd != REG_ZERO) ? K_ALU : K_ADV;
        end else if (opc == OPC_FENCE) begin
            o_op.kind = K_ADV;
        end else begin
            o_op.kind = K_HALT;
        end
    end

endmodule

// ----- src/rv64ae_queue.sv -----
module rv64ae_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rv64ae_pkg::t_op i_op,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rv64ae_pkg::t_op o_op
);
    import rv64ae_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];

endmodule

// ----- src/rv64ae_back.sv -----
module rv64ae_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  rv64ae_pkg::t_op i_q_op,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_status,
    output logic [4:0]      o_dest_index,
    output logic [63:0]     o_dest_value,
    output logic [63:0]     o_pc_after
);
    import rv64ae_pkg::*;

    // execute stage
    logic                r_busy;
    t_op                 r_op;
    // last write, which the RAM read issued alongside it missed
    logic                r_fwd_en;
    logic [REG_BITS-1:0] r_fwd_addr;
    logic [XLEN-1:0]     r_fwd_val;
    // architectural state
    logic [NUM_REGS-1:0] r_written;
    logic [XLEN-1:0]     r_pc, n_pc;
    logic                r_halted, n_halted;
    // result register
    logic                r_out_valid;
    logic [2:0]          r_status;
    logic [REG_BITS-1:0] r_dest;
    logic [XLEN-1:0]     r_value;
    logic [XLEN-1:0]     r_pc_out;

    logic                out_free, commit, pop;
    logic [XLEN-1:0]     q1, q2, a, b, res;
    logic [SH_BITS-1:0]  sh;
    logic                wr;
    logic [2:0]          st;

    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = r_busy && out_free;
    assign pop      = i_q_valid && (!r_busy || commit);
    assign o_q_pop  = pop;

    rv64ae_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk  (i_clk),
        .i_we   (commit && wr),
        .i_waddr(r_op.rd),
        .i_wdata(res),
        .i_re   (pop),
        .i_raddr(i_q_op.rs1),
        .o_rdata(q1)
    );

    rv64ae_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk  (i_clk),
        .i_we   (commit && wr),
        .i_waddr(r_op.rd),
        .i_wdata(res),
        .i_re   (pop),
        .i_raddr(i_q_op.rs2),
        .o_rdata(q2)
    );

    // never-written registers read as zero
    always_comb begin
        if (r_fwd_en && r_fwd_addr == r_op.rs1) begin
            a = r_fwd_val;
        end else begin
            a = r_written[r_op.rs1] ? q1 : '0;
        end
        if (r_fwd_en && r_fwd_addr == r_op.rs2) begin
            b = r_fwd_val;
        end else begin
            b = r_written[r_op.rs2] ? q2 : '0;
        end
    end

    assign sh = b[SH_BITS-1:0];

    always_comb begin
        st       = ST_ADVANCED;
        wr       = 1'b0;
        res      = r_op.value;
        n_pc     = r_pc;
        n_halted = r_halted;
        case (r_op.alu)
            A_ADD:   res = a + b;
            A_SUB:   res = a - b;
            A_SLL:   res = a << sh;
            A_SLT:   res = XLEN'($signed(a) < $signed(b));
            A_SLTU:  res = XLEN'(a < b);
            A_XOR:   res = a ^ b;
            A_SRL:   res = a >> sh;
            A_SRA:   res = $signed(a) >>> sh;
            A_OR:    res = a | b;
            default: res = a & b;
        endcase
        case (r_op.kind)
            K_LOAD: begin
                st  = ST_LOADED;
                wr  = (r_op.rd != REG_ZERO);
                res = r_op.value;
            end
            K_ALU: begin
                if (r_halted) begin
                    st = ST_IGNORED;
                end else begin
                    st   = ST_WRITTEN;
                    wr   = 1'b1;
                    n_pc = r_pc + PC_STEP;
                end
            end
            K_ADV: begin
                if (r_halted) begin
                    st = ST_IGNORED;
                end else begin
                    n_pc = r_pc + PC_STEP;
                end
            end
            default: begin
                if (r_halted) begin
                    st = ST_IGNORED;
                end else begin
                    st       = ST_HALT;
                    n_halted = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fwd_en    <= 1'b0;
            r_written   <= '0;
            r_pc        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_busy   <= 1'b1;
                r_fwd_en <= commit && wr;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (commit) begin
                r_pc        <= n_pc;
                r_halted    <= n_halted;
                r_out_valid <= 1'b1;
                if (wr) begin
                    r_written[r_op.rd] <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop) begin
            r_op       <= i_q_op;
            r_fwd_addr <= r_op.rd;
            r_fwd_val  <= res;
        end
        if (commit) begin
            r_status <= st;
            r_dest   <= wr ? r_op.rd : REG_ZERO;
            r_value  <= wr ? res : '0;
            r_pc_out <= n_pc;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_dest_index = r_dest;
    assign o_dest_value = r_value;
    assign o_pc_after   = r_pc_out;

endmodule

// ----- src/rv64_register_alu_executor.sv -----
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+-----------------------------------------
// in      | input     | i_in_valid / o_in_stall  | i_item_kind, i_instruction_word,
//         |           |                          | i_load_index, i_load_value
// out     | output    | o_out_valid / i_out_stall| o_status, o_dest_index, o_dest_value,
//         |           |                          | o_pc_after
//
// One request per cycle sustained while the output does not stall; a request's result
// passes from the queue through the execute stage (register read and ALU) into the
// result register before it is offered.
// The register file RAMs have a registered read port.
// Synchronous active-low reset empties the queue and clears pc, halt and the written
// bits of the register file; registers never written read as zero.
// o_in_stall rises only when the request queue is full; a stalled output holds its
// result while the queue keeps taking requests.
module rv64_register_alu_executor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_item_kind,
    input  logic [31:0] i_instruction_word,
    input  logic [4:0]  i_load_index,
    input  logic [63:0] i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_dest_index,
    output logic [63:0] o_dest_value,
    output logic [63:0] o_pc_after
);
    import rv64ae_pkg::*;

    t_op  dec_op;   // classified request from the front end
    t_op  q_op;     // head of the queue
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;

    // Front end: decode and classify; holds no architectural state.
    rv64ae_front u_front (
        .i_item_kind       (i_item_kind),
        .i_instruction_word(i_instruction_word),
        .i_load_index      (i_load_index),
        .i_load_value      (i_load_value),
        .o_op              (dec_op)
    );

    assign push       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    // Short queue so front and back stall independently.
    rv64ae_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (dec_op),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_op   (q_op)
    );

    // Back end: register read, ALU, write back, pc/halt and the result register.
    rv64ae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_dest_index(o_dest_index),
        .o_dest_value(o_dest_value),
        .o_pc_after  (o_pc_after)
    );

endmodule
